@@ sv/mqds_pkg.sv @@
package mqds_pkg;

	localparam int STATIONS    = 5;
	localparam int QUEUE_DEPTH = 64;
	localparam int ST_W        = $clog2(STATIONS);
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_DEPTH = STATIONS * QUEUE_DEPTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int TOTAL_W     = $clog2(STORE_DEPTH + 1);
	localparam int IN_W        = 24;
	localparam int OUT_W       = 256;

	localparam logic [31:0] ID_START = 32'd1010;

	localparam logic [1:0] POL_RR    = 2'd0;
	localparam logic [1:0] POL_SHORT = 2'd1;
	localparam logic [1:0] POL_EXT   = 2'd2;

	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_PERIOD = 1'b1;

	typedef logic [ST_W-1:0] st_idx_t;

	function automatic st_idx_t clamp_st(input logic [2:0] v);
		if (int'(v) >= STATIONS) begin
			return st_idx_t'(STATIONS - 1);
		end
		return st_idx_t'(v);
	endfunction

endpackage

@@ sv/mqds_ram.sv @@
module mqds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 320
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/multi_queue_dispatch_and_service_core.sv @@
// Tick-driven dispatcher for five FIFO queues, each feeding one service station. Every input
// item is one tick and yields exactly one result item. One state takes the item in, a bit-serial
// remainder unit then decides whether the tick is an arrival tick, and one state dispatches the
// arrival. The station sequencer visits each of the five stations in turn: one read of the shared
// arrival-time memory, then one statistics update. A final state forms the result. The input
// side is not ready while an item is in work. A finished result waits in an output register,
// so the next item may be taken before it is collected. Only while that register is still full
// at the end of the next item does the core hold in its final state.
module multi_queue_dispatch_and_service_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// accept_arrivals, random_pick, service_time, report_station
	input  logic [mqds_pkg::IN_W-1:0] s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// arrived, dropped, dest_queue, customer_id, started_mask, queued_total, time_now,
	// rep_max_len, rep_wait_sum, rep_max_wait, rep_customers, rep_busy_sum
	output logic [mqds_pkg::OUT_W-1:0] m_axis_tdata
);
	import mqds_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_ARR  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_WB   = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]  state_q;
	logic [1:0]  policy_q;
	logic [15:0] period_q;
	logic [31:0] tick_q;
	st_idx_t     rr_q;
	logic [31:0] next_id_q;

	logic [PTR_W-1:0] head_q [STATIONS];
	logic [PTR_W-1:0] tail_q [STATIONS];
	logic [CNT_W-1:0] cnt_q  [STATIONS];
	logic [15:0]      busy_q [STATIONS];
	logic [CNT_W-1:0] peak_q [STATIONS];
	logic [47:0]      wsum_q [STATIONS];
	logic [31:0]      wmax_q [STATIONS];
	logic [31:0]      served_q [STATIONS];
	logic [47:0]      bsum_q [STATIONS];

	logic        acc_q;
	logic [2:0]  pick_q;
	logic [15:0] svc_q;
	st_idx_t     rep_q;

	logic [4:0]  bit_q;
	logic [16:0] rem_q;
	st_idx_t     st_q;
	logic        go_q;

	logic              arrived_q;
	logic              dropped_q;
	st_idx_t           dest_q;
	logic [31:0]       cid_q;
	logic [STATIONS-1:0] mask_q;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [31:0]       mem_rdata;

	logic [16:0]  period_eff;
	logic [16:0]  rem_sh;
	st_idx_t      short_c;
	st_idx_t      dest_c;
	st_idx_t      rr_c;
	logic         arr_c;
	logic         full_c;
	logic [31:0]  wait_c;
	logic [TOTAL_W-1:0] total_c;

	mqds_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(tick_q),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		period_eff = (period_q == 16'd0) ? 17'd1 : {1'b0, period_q};
		rem_sh     = {rem_q[15:0], tick_q[bit_q]};
		wait_c     = tick_q - mem_rdata;
	end

	always_comb begin
		short_c = '0;
		for (int s = 1; s < STATIONS; s++) begin
			if (cnt_q[s] < cnt_q[short_c]) begin
				short_c = st_idx_t'(s);
			end
		end
	end

	always_comb begin
		rr_c = (int'(rr_q) < STATIONS) ? rr_q : '0;
		unique case (policy_q)
			POL_SHORT: dest_c = short_c;
			POL_EXT:   dest_c = clamp_st(pick_q);
			default:   dest_c = rr_c;
		endcase
		arr_c  = acc_q && (rem_q == 17'd0);
		full_c = (int'(cnt_q[dest_c]) >= QUEUE_DEPTH);
	end

	always_comb begin
		total_c = '0;
		for (int s = 0; s < STATIONS; s++) begin
			total_c = total_c + TOTAL_W'(cnt_q[s]);
		end
	end

	always_comb begin
		mem_we    = (state_q == S_ARR) && arr_c && !full_c;
		mem_waddr = ADDR_W'(int'(dest_c) * QUEUE_DEPTH + int'(tail_q[dest_c]));
		mem_raddr = ADDR_W'(int'(st_q) * QUEUE_DEPTH + int'(head_q[st_q]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			policy_q    <= POL_RR;
			period_q    <= 16'd1;
			tick_q      <= '0;
			rr_q        <= '0;
			next_id_q   <= ID_START;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			acc_q       <= 1'b0;
			pick_q      <= '0;
			svc_q       <= '0;
			rep_q       <= '0;
			bit_q       <= '0;
			rem_q       <= '0;
			st_q        <= '0;
			go_q        <= 1'b0;
			arrived_q   <= 1'b0;
			dropped_q   <= 1'b0;
			dest_q      <= '0;
			cid_q       <= '0;
			mask_q      <= '0;
			for (int s = 0; s < STATIONS; s++) begin
				head_q[s]   <= '0;
				tail_q[s]   <= '0;
				cnt_q[s]    <= '0;
				busy_q[s]   <= '0;
				peak_q[s]   <= '0;
				wsum_q[s]   <= '0;
				wmax_q[s]   <= '0;
				served_q[s] <= '0;
				bsum_q[s]   <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_POLICY: policy_q <= cfg_data[1:0];
					REG_PERIOD: period_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && m_axis_tready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						acc_q   <= s_axis_tdata[0];
						pick_q  <= s_axis_tdata[3:1];
						svc_q   <= s_axis_tdata[19:4];
						rep_q   <= clamp_st(s_axis_tdata[22:20]);
						rem_q   <= '0;
						bit_q   <= 5'd31;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= (rem_sh >= period_eff) ? rem_sh - period_eff : rem_sh;
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd0) begin
						state_q <= S_ARR;
					end
				end
				S_ARR: begin
					arrived_q <= arr_c && !full_c;
					dropped_q <= arr_c && full_c;
					dest_q    <= arr_c ? dest_c : '0;
					cid_q     <= arr_c ? next_id_q : '0;
					mask_q    <= '0;
					if (arr_c) begin
						next_id_q <= next_id_q + 32'd1;
						if (policy_q != POL_SHORT && policy_q != POL_EXT) begin
							rr_q <= (int'(rr_c) + 1 >= STATIONS) ? '0 : rr_c + st_idx_t'(1);
						end
						if (!full_c) begin
							tail_q[dest_c] <= (int'(tail_q[dest_c]) == QUEUE_DEPTH - 1) ? '0
							                  : tail_q[dest_c] + PTR_W'(1);
							cnt_q[dest_c]    <= cnt_q[dest_c] + CNT_W'(1);
							served_q[dest_c] <= served_q[dest_c] + 32'd1;
							if (cnt_q[dest_c] + CNT_W'(1) > peak_q[dest_c]) begin
								peak_q[dest_c] <= cnt_q[dest_c] + CNT_W'(1);
							end
						end
					end
					for (int s = 0; s < STATIONS; s++) begin
						if (busy_q[s] != 16'd0) begin
							busy_q[s] <= busy_q[s] - 16'd1;
						end
					end
					st_q    <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					go_q    <= (busy_q[st_q] == 16'd0) && (cnt_q[st_q] != '0);
					state_q <= S_WB;
				end
				S_WB: begin
					if (go_q) begin
						head_q[st_q] <= (int'(head_q[st_q]) == QUEUE_DEPTH - 1) ? '0
						                : head_q[st_q] + PTR_W'(1);
						cnt_q[st_q]  <= cnt_q[st_q] - CNT_W'(1);
						wsum_q[st_q] <= wsum_q[st_q] + {16'd0, wait_c};
						if (wait_c > wmax_q[st_q]) begin
							wmax_q[st_q] <= wait_c;
						end
						busy_q[st_q] <= svc_q;
						bsum_q[st_q] <= bsum_q[st_q] + {32'd0, svc_q};
						mask_q[st_q] <= 1'b1;
					end
					if (int'(st_q) == STATIONS - 1) begin
						state_q <= S_FIN;
					end else begin
						st_q    <= st_q + st_idx_t'(1);
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {6'd0, bsum_q[rep_q], served_q[rep_q], wmax_q[rep_q],
						                wsum_q[rep_q], peak_q[rep_q], tick_q,
						                9'(total_c), 5'(mask_q), 32'(cid_q), 3'(dest_q),
						                dropped_q, arrived_q};
						tick_q      <= tick_q + 32'd1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

import mqds_pkg::*;

typedef struct packed {
	logic [5:0]  pad;
	logic [47:0] busy_sum;
	logic [31:0] customers;
	logic [31:0] max_wait;
	logic [47:0] wait_sum;
	logic [6:0]  max_len;
	logic [31:0] time_now;
	logic [8:0]  queued_total;
	logic [4:0]  started_mask;
	logic [31:0] customer_id;
	logic [2:0]  dest_queue;
	logic        dropped;
	logic        arrived;
} tick_result_t;

class dispatch_scoreboard;
	logic [1:0]   policy;
	logic [15:0]  period;
	logic [31:0]  tick;
	logic [31:0]  next_id;
	logic [2:0]   rr_ptr;
	logic [31:0]  arrival_q[STATIONS][$];
	logic [15:0]  busy_left[STATIONS];
	logic [6:0]   peak_len[STATIONS];
	logic [47:0]  wait_total[STATIONS];
	logic [31:0]  wait_peak[STATIONS];
	logic [31:0]  served[STATIONS];
	logic [47:0]  busy_total[STATIONS];
	tick_result_t pending[$];
	int           errors;
	int           accepted;

	function new();
		policy = POL_RR;
		period = 16'd1;
		tick = '0;
		next_id = ID_START;
		rr_ptr = '0;
		errors = 0;
		accepted = 0;
		for (int s = 0; s < STATIONS; s++) begin
			busy_left[s] = '0;
			peak_len[s] = '0;
			wait_total[s] = '0;
			wait_peak[s] = '0;
			served[s] = '0;
			busy_total[s] = '0;
		end
	endfunction

	function int clamp(logic [2:0] v);
		return (int'(v) >= STATIONS) ? STATIONS - 1 : int'(v);
	endfunction

	// work out the result of one tick
	function void note_tick(logic [IN_W-1:0] d);
		tick_result_t r;
		logic [15:0]  svc;
		logic [31:0]  per;
		logic [31:0]  wt;
		int           rep;
		int           q;
		int           total;
		svc = d[19:4];
		rep = clamp(d[22:20]);
		per = (period == 0) ? 32'd1 : {16'd0, period};
		r = '0;
		r.time_now = tick;
		accepted++;
		if (d[0] && (tick % per) == 0) begin
			r.customer_id = next_id;
			next_id = next_id + 32'd1;
			if (policy == POL_SHORT) begin
				q = 0;
				for (int s = 1; s < STATIONS; s++)
					if (arrival_q[s].size() < arrival_q[q].size())
						q = s;
			end else if (policy == POL_EXT) begin
				q = clamp(d[3:1]);
			end else begin
				q = (rr_ptr < STATIONS) ? int'(rr_ptr) : 0;
				rr_ptr = (q + 1 >= STATIONS) ? 3'd0 : 3'(q + 1);
			end
			r.dest_queue = 3'(q);
			if (arrival_q[q].size() >= QUEUE_DEPTH) begin
				r.dropped = 1'b1;
			end else begin
				r.arrived = 1'b1;
				arrival_q[q].push_back(tick);
				served[q] = served[q] + 32'd1;
				if (arrival_q[q].size() > peak_len[q])
					peak_len[q] = 7'(arrival_q[q].size());
			end
		end
		for (int s = 0; s < STATIONS; s++)
			if (busy_left[s] != 0)
				busy_left[s] = busy_left[s] - 16'd1;
		total = 0;
		for (int s = 0; s < STATIONS; s++) begin
			if (busy_left[s] == 0 && arrival_q[s].size() != 0) begin
				wt = tick - arrival_q[s].pop_front();
				wait_total[s] = wait_total[s] + {16'd0, wt};
				if (wt > wait_peak[s])
					wait_peak[s] = wt;
				busy_left[s] = svc;
				busy_total[s] = busy_total[s] + {32'd0, svc};
				r.started_mask[s] = 1'b1;
			end
			total += arrival_q[s].size();
		end
		tick = tick + 32'd1;
		r.queued_total = 9'(total);
		r.max_len = peak_len[rep];
		r.wait_sum = wait_total[rep];
		r.max_wait = wait_peak[rep];
		r.customers = served[rep];
		r.busy_sum = busy_total[rep];
		pending.push_back(r);
	endfunction

	function void cmp(string f, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$display("%0t %s expected %0h actual %0h", $time, f, e, a);
			errors++;
		end
	endfunction

	function void check_result(logic [OUT_W-1:0] d);
		tick_result_t a;
		tick_result_t e;
		a = d;
		if (pending.size() == 0) begin
			$display("%0t unexpected result expected none actual %0h", $time, d);
			errors++;
			return;
		end
		e = pending.pop_front();
		cmp("arrived", 64'(e.arrived), 64'(a.arrived));
		cmp("dropped", 64'(e.dropped), 64'(a.dropped));
		cmp("dest_queue", 64'(e.dest_queue), 64'(a.dest_queue));
		cmp("customer_id", 64'(e.customer_id), 64'(a.customer_id));
		cmp("started_mask", 64'(e.started_mask), 64'(a.started_mask));
		cmp("queued_total", 64'(e.queued_total), 64'(a.queued_total));
		cmp("time_now", 64'(e.time_now), 64'(a.time_now));
		cmp("rep_max_len", 64'(e.max_len), 64'(a.max_len));
		cmp("rep_wait_sum", 64'(e.wait_sum), 64'(a.wait_sum));
		cmp("rep_max_wait", 64'(e.max_wait), 64'(a.max_wait));
		cmp("rep_customers", 64'(e.customers), 64'(a.customers));
		cmp("rep_busy_sum", 64'(e.busy_sum), 64'(a.busy_sum));
		cmp("pad", 64'(e.pad), 64'(a.pad));
	endfunction
endclass

module tb;
	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic                 cfg_index;
	logic [15:0]          cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_W-1:0]      s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;

	dispatch_scoreboard sb;
	int burst_left;

	multi_queue_dispatch_and_service_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int hold;
		bit held;
		hold = 0;
		held = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && sb != null && sb.accepted >= 700) begin
				held = 1;
				hold = 600;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (($urandom_range(99) < 5)) begin
				hold = $urandom_range(30);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) < 75);
			end
		end
	end

	initial begin
		#50ms;
		$display("tb: errors");
		$finish;
	end

	task automatic send_tick(logic acc, logic [2:0] pick, logic [15:0] svc, logic [2:0] rep);
		s_axis_tdata <= {1'b0, rep, svc, pick, acc};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_tick(s_axis_tdata);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			int gap;
			burst_left = $urandom_range(40);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic write_config(logic [1:0] pol, logic [15:0] per);
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_POLICY;
		cfg_data <= {14'd0, pol};
		@(negedge clk);
		cfg_index <= REG_PERIOD;
		cfg_data <= per;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.policy = pol;
		sb.period = per;
	endtask

	task automatic run_phase(logic [1:0] pol, logic [15:0] per, int n, int svc_max, int pick_max);
		write_config(pol, per);
		for (int i = 0; i < n; i++)
			send_tick($urandom_range(9) != 0, 3'($urandom_range(pick_max)),
				16'($urandom_range(svc_max)), 3'($urandom_range(7)));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_POLICY;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		burst_left = 0;
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings, zero period, unused policy, clamping
		send_tick(1'b0, 3'd0, 16'd5, 3'd0);
		send_tick(1'b1, 3'd7, 16'd0, 3'd7);
		send_tick(1'b1, 3'd0, 16'd65535, 3'd0);
		send_tick(1'b1, 3'd0, 16'd1, 3'd1);
		write_config(2'd3, 16'd0);
		for (int i = 0; i < 6; i++)
			send_tick(1'b1, 3'd0, 16'd0, 3'(i));
		write_config(POL_EXT, 16'd1);
		send_tick(1'b1, 3'd7, 16'd2, 3'd4);
		send_tick(1'b1, 3'd5, 16'd2, 3'd6);
		send_tick(1'b1, 3'd0, 16'd0, 3'd0);
		send_tick(1'b1, 3'd2, 16'd3, 3'd2);
		write_config(POL_SHORT, 16'd2);
		for (int i = 0; i < 6; i++)
			send_tick(1'b1, 3'd0, 16'd1, 3'd7);

		run_phase(POL_RR, 16'd1, 300, 6, 7);
		run_phase(POL_SHORT, 16'd1, 300, 8, 7);
		run_phase(POL_EXT, 16'd2, 300, 10, 7);
		run_phase(POL_SHORT, 16'd3, 200, 20, 7);
		run_phase(2'd3, 16'd0, 200, 5, 7);
		run_phase(POL_EXT, 16'd65535, 40, 5, 7);
		run_phase(POL_EXT, 16'd1, 300, 65535, 7);
		run_phase(POL_EXT, 16'd1, 200, 65535, 1);
		run_phase(POL_SHORT, 16'd1, 200, 65535, 7);

		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

@@ multi_queue_dispatch_and_service_core.f @@
sv/mqds_pkg.sv
sv/mqds_ram.sv
sv/multi_queue_dispatch_and_service_core.sv
tb/tb.sv
